// ===== src/lmpsd_pkg.sv =====
package lmpsd_pkg;

    localparam int COLUMNS    = 128;
    localparam int ROW_PAIRS  = 16;
    localparam int BIT_PLANES = 3;

    localparam int ROW_BYTES = COLUMNS / 8;
    localparam int ENTRIES   = ROW_PAIRS * ROW_BYTES;
    localparam int ENTRY_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENTRY_W   = 2 * BIT_PLANES * 8;
    localparam int GRP_W     = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int ROW_W     = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
    localparam int PLANE_W   = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;

    localparam int CLOCK_PLANE = 2;
    localparam int VALUE_BITS  = 3;

    localparam logic [1:0] MODE_PIXEL   = 2'd0;
    localparam logic [1:0] MODE_REFRESH = 2'd1;
    localparam logic [1:0] MODE_SWAP    = 2'd2;

    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;

    localparam logic [2:0] CFG_BRIGHTNESS  = 3'd0;
    localparam logic [2:0] CFG_TIME_BRIGHT = 3'd1;
    localparam logic [2:0] CFG_TIME_COLOR  = 3'd2;
    localparam logic [2:0] CFG_ANIM_COLOR  = 3'd3;
    localparam logic [2:0] CFG_DBUF_EN     = 3'd4;

    localparam logic [2:0] BRIGHT_MAX = 3'd6;

    localparam int T_BASE        = 100;
    localparam int T_PLANE1      = 400;
    localparam int T_PLANE1_STEP = 300;
    localparam int T_CLOCK_STEP  = 400;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] pixel_x;
        logic [4:0] pixel_y;
        logic [2:0] pixel_value;
        logic       wait_for_frame;
    } t_in;

    typedef struct packed {
        logic [3:0]  row_address;
        logic [3:0]  column_group;
        logic [31:0] port_data;
        logic [1:0]  bit_plane;
        logic [12:0] row_time;
        logic        last;
    } t_out;

    typedef struct packed {
        logic                pix_go;
        logic                rd_go;
        logic [ENTRY_AW-1:0] addr;
        logic                half;
        logic [2:0]          col;
        logic [2:0]          value;
    } t_fb_cmd;

    typedef enum logic [1:0] {
        FB_CLEAR,
        FB_IDLE,
        FB_MODIFY
    } t_fb_state;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_scan_state;

    function automatic logic [31:0] pack_group(input logic [7:0] upper,
                                               input logic [7:0] lower,
                                               input logic [1:0] color);
        logic [31:0] word;
        logic        u;
        logic        l;
        word = '0;
        for (int k = 0; k < 8; k++) begin
            u = upper[7-k];
            l = lower[7-k];
            if (color == COLOR_GREEN) begin
                word[4*k +: 4] = {u, l, 1'b0, 1'b0};
            end else if (color == COLOR_RED) begin
                word[4*k +: 4] = {1'b0, 1'b0, u, l};
            end else begin
                word[4*k +: 4] = {u, l, u, l};
            end
        end
        return word;
    endfunction

endpackage

// ===== src/lmpsd_fb.sv =====
module lmpsd_fb (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lmpsd_pkg::t_fb_cmd               i_cmd,
    output logic                             o_busy,
    output logic [lmpsd_pkg::ENTRY_W-1:0]    o_rd_data
);
    import lmpsd_pkg::*;

    logic [ENTRY_W-1:0]  r_mem [ENTRIES];
    logic [ENTRY_W-1:0]  r_rd_data;
    t_fb_state           r_state;
    t_fb_state           n_state;
    logic [ENTRY_AW-1:0] r_clr_addr;
    logic [ENTRY_AW-1:0] r_addr;
    logic                r_half;
    logic [2:0]          r_col;
    logic [2:0]          r_value;

    logic                we;
    logic [ENTRY_AW-1:0] wa;
    logic [ENTRY_W-1:0]  wd;
    logic                re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FB_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FB_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FB_IDLE && i_cmd.pix_go) begin
            r_addr  <= i_cmd.addr;
            r_half  <= i_cmd.half;
            r_col   <= i_cmd.col;
            r_value <= i_cmd.value;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FB_CLEAR: begin
                if (32'(r_clr_addr) == ENTRIES - 1) begin
                    n_state = FB_IDLE;
                end
            end
            FB_IDLE: begin
                if (i_cmd.pix_go) begin
                    n_state = FB_MODIFY;
                end
            end
            FB_MODIFY: n_state = FB_IDLE;
            default:   n_state = FB_IDLE;
        endcase
    end

    always_comb begin
        logic [7:0] v_sh;
        wd = r_rd_data;
        for (int p = 0; p < BIT_PLANES; p++) begin
            v_sh = 8'(r_value) >> p;
            wd[(p * 2 + 32'(r_half)) * 8 + 7 - 32'(r_col)] = (p < VALUE_BITS) && v_sh[0];
        end
        we = 1'b0;
        wa = r_addr;
        if (r_state == FB_CLEAR) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = '0;
        end else if (r_state == FB_MODIFY) begin
            we = 1'b1;
        end
        re = (r_state == FB_IDLE) && (i_cmd.pix_go || i_cmd.rd_go);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rd_data <= r_mem[i_cmd.addr];
        end
    end

    assign o_busy    = (r_state != FB_IDLE);
    assign o_rd_data = r_rd_data;

    a_modify_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == FB_MODIFY |=> r_state == FB_IDLE)
        else $error("read-modify-write did not finish in one cycle");

    a_cmd_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pix_go || i_cmd.rd_go) |-> r_state == FB_IDLE)
        else $error("frame store access while busy");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_go |-> !i_cmd.pix_go)
        else $error("scan read collides with pixel write");

endmodule

// ===== src/led_matrix_plane_scan_driver_unit.sv =====
// channel  | valid      | ready       | payload
// ---------+------------+-------------+----------------------------
// input    | i_in_valid | o_in_ready  | i_in_data  (t_in)
// output   | o_out_valid| i_out_ready | o_out_data (t_out)
// config   | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// Pixel write: read-modify-write of one frame store entry.
// Swap and unused modes: no frame store access. Refresh: the accepting cycle,
// then 16 groups with one frame store read per cycle while the output does not
// stall, and then the registered read data of the last group.
// After reset the frame store is swept to zero, one entry a cycle, with no
// transaction accepted on the input channel until all 256 entries are cleared.
// Output stalls hold the read stage; scanning resumes when the output drains.
module led_matrix_plane_scan_driver_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lmpsd_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lmpsd_pkg::t_out  o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);
    import lmpsd_pkg::*;

    logic [2:0] r_brightness;
    logic [3:0] r_time_bright;
    logic [1:0] r_time_color;
    logic [1:0] r_anim_color;
    logic       r_dbuf_en;

    t_scan_state          r_state;
    t_scan_state          n_state;
    logic [ROW_W-1:0]     r_row;
    logic [PLANE_W-1:0]   r_plane;
    logic                 r_shown_set;
    logic                 r_swap_pending;
    logic [GRP_W-1:0]     r_grp;

    logic [ROW_W-1:0]     r_ctx_row;
    logic [PLANE_W-1:0]   r_ctx_plane;
    logic [12:0]          r_ctx_time;
    logic [1:0]           r_ctx_color;
    logic                 r_ctx_blank;

    logic                 r_rd_vld;
    logic [GRP_W-1:0]     r_rd_grp;
    logic                 r_out_valid;
    t_out                 r_out;

    t_fb_cmd              fb_cmd;
    logic                 fb_busy;
    logic [ENTRY_W-1:0]   fb_rd_data;

    logic                 in_fire;
    logic                 adv;
    logic                 issue;
    logic                 grp_end;
    logic                 row_end;
    logic                 plane_end;
    logic                 pix_in_panel;
    logic                 pix_half;
    int                   pix_rp;
    logic [12:0]          row_time;
    logic [7:0]           upper_b;
    logic [7:0]           lower_b;

    lmpsd_fb u_fb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (fb_cmd),
        .o_busy    (fb_busy),
        .o_rd_data (fb_rd_data)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness  <= '0;
            r_time_bright <= '0;
            r_time_color  <= '0;
            r_anim_color  <= '0;
            r_dbuf_en     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS: begin
                    if (i_cfg_data[2:0] <= BRIGHT_MAX) begin
                        r_brightness <= i_cfg_data[2:0];
                    end
                end
                CFG_TIME_BRIGHT: r_time_bright <= i_cfg_data[3:0];
                CFG_TIME_COLOR:  r_time_color  <= i_cfg_data[1:0];
                CFG_ANIM_COLOR:  r_anim_color  <= i_cfg_data[1:0];
                CFG_DBUF_EN:     r_dbuf_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE) && !r_rd_vld && !fb_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    assign adv        = !r_out_valid || i_out_ready;
    assign issue      = (r_state == ST_SCAN) && adv;
    assign grp_end    = (32'(r_grp) == ROW_BYTES - 1);
    assign row_end    = (32'(r_row) == ROW_PAIRS - 1);
    assign plane_end  = (32'(r_plane) == BIT_PLANES - 1);

    always_comb begin
        pix_half     = 32'(i_in_data.pixel_y) >= ROW_PAIRS;
        pix_rp       = pix_half ? 32'(i_in_data.pixel_y) - ROW_PAIRS
                                : 32'(i_in_data.pixel_y);
        pix_in_panel = (32'(i_in_data.pixel_x) < COLUMNS)
                    && (32'(i_in_data.pixel_y) < 2 * ROW_PAIRS);

        fb_cmd        = '0;
        fb_cmd.half   = pix_half;
        fb_cmd.col    = i_in_data.pixel_x[2:0];
        fb_cmd.value  = i_in_data.pixel_value;
        if (r_state == ST_SCAN) begin
            fb_cmd.rd_go = issue;
            fb_cmd.addr  = ENTRY_AW'(32'(r_ctx_row) * ROW_BYTES + 32'(r_grp));
        end else begin
            fb_cmd.pix_go = in_fire && (i_in_data.mode == MODE_PIXEL) && pix_in_panel;
            fb_cmd.addr   = ENTRY_AW'(pix_rp * ROW_BYTES + 32'(i_in_data.pixel_x >> 3));
        end
    end

    always_comb begin
        row_time = 13'(T_BASE) + 13'(r_brightness) * 13'(T_BASE);
        if (32'(r_plane) == 1) begin
            row_time = row_time + 13'(T_PLANE1) + 13'(r_brightness) * 13'(T_PLANE1_STEP);
        end else if (32'(r_plane) == CLOCK_PLANE) begin
            row_time = row_time + 13'(r_time_bright) * 13'(T_CLOCK_STEP);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_in_data.mode == MODE_REFRESH) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue && grp_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_row          <= '0;
            r_plane        <= '0;
            r_shown_set    <= 1'b0;
            r_swap_pending <= 1'b0;
            r_grp          <= '0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_grp <= r_grp + 1'b1;
            end
            if (in_fire && i_in_data.mode == MODE_SWAP && r_dbuf_en) begin
                if (i_in_data.wait_for_frame) begin
                    r_swap_pending <= 1'b1;
                end else begin
                    r_shown_set    <= !r_shown_set;
                    r_swap_pending <= 1'b0;
                end
            end
            if (in_fire && i_in_data.mode == MODE_REFRESH) begin
                r_grp <= '0;
                if (row_end) begin
                    r_row <= '0;
                    if (plane_end) begin
                        r_plane <= '0;
                        if (r_dbuf_en && r_swap_pending) begin
                            r_shown_set    <= !r_shown_set;
                            r_swap_pending <= 1'b0;
                        end
                    end else begin
                        r_plane <= r_plane + 1'b1;
                    end
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in_data.mode == MODE_REFRESH) begin
            r_ctx_row   <= r_row;
            r_ctx_plane <= r_plane;
            r_ctx_time  <= row_time;
            r_ctx_color <= (32'(r_plane) == CLOCK_PLANE) ? r_time_color : r_anim_color;
            r_ctx_blank <= r_shown_set;
        end
    end

    assign upper_b = fb_rd_data[32'(r_ctx_plane) * 16 +: 8];
    assign lower_b = fb_rd_data[32'(r_ctx_plane) * 16 + 8 +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_rd_vld    <= issue;
            r_out_valid <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_grp <= r_grp;
            if (r_rd_vld) begin
                r_out.row_address  <= 4'(r_ctx_row);
                r_out.column_group <= 4'(r_rd_grp);
                r_out.port_data    <= r_ctx_blank ? 32'd0
                                    : pack_group(upper_b, lower_b, r_ctx_color);
                r_out.bit_plane    <= 2'(r_ctx_plane);
                r_out.row_time     <= r_ctx_time;
                r_out.last         <= (32'(r_rd_grp) == ROW_BYTES - 1);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_refresh_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.mode == MODE_REFRESH |=> r_state == ST_SCAN)
        else $error("refresh did not start a scan");

    a_pixel_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fb_cmd.pix_go |=> !o_in_ready)
        else $error("input accepted during pixel read-modify-write");

    a_set_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shown_set != $past(r_shown_set) |-> $past(in_fire))
        else $error("shown set changed without a transaction");

    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> 32'(r_grp) < ROW_BYTES)
        else $error("group counter out of range");

endmodule
